>>> src/gsds_pkg.sv
// ----------------------------------------------------------------------------
// gsds_pkg: shared types and constants for the diffusion solver
// Request codes, register indexes, default sizes and the transfer payloads.
// ----------------------------------------------------------------------------
package gsds_pkg;

  localparam int GRID_MAX_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SIZE_W  = 7;
  localparam int GAIN_W  = 31;
  localparam int SCALE_W = 17;
  localparam int CFG_W   = 31;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [1:0] CFG_ACTIVE_SIZE   = 2'd0;
  localparam logic [1:0] CFG_NEIGHBOR_GAIN = 2'd1;
  localparam logic [1:0] CFG_CENTER_SCALE  = 2'd2;

  localparam logic [SIZE_W-1:0]  ACTIVE_SIZE_RST  = 7'd64;
  localparam logic [GAIN_W-1:0]  NEIGHBOR_GAIN_RST = '0;
  localparam logic [SCALE_W-1:0] CENTER_SCALE_RST = 17'd65536;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [6:0]         cell_row;
    logic [6:0]         cell_col;
    logic signed [31:0] source_value;
    logic signed [31:0] start_value;
    logic [7:0]         sweep_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic               done_res;
    logic               saturated;
  } out_item_t;

endpackage

>>> src/gauss_seidel_diffusion_solver_unit.sv
// ----------------------------------------------------------------------------
// gauss_seidel_diffusion_solver_unit
// Padded-grid Gauss-Seidel diffusion with a zeroed boundary ring.
// ----------------------------------------------------------------------------
// A load writes its result register on acceptance and a read first passes
// through the read-out state; the next item is taken once the unit is idle and
// the result register is free. A run visits the N x N interior cell by cell:
// each cell fetches its neighbours and source from the field and source
// memories in the fetch states, is set up, multiplies the neighbour sum by the
// gain in 17-bit slices on one 31x17 multiplier, adds and compares, multiplies
// the sum by the centre scale on the same multiplier, rounds and is written
// back; the boundary ring is then zeroed. The speed of a run is limited by the
// shared multiplier and the single field write port.
module gauss_seidel_diffusion_solver_unit
  import gsds_pkg::*;
#(
  parameter int GRID_MAX   = GRID_MAX_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int EDGE  = GRID_MAX + 2;
  localparam int DEPTH = EDGE * EDGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(EDGE);
  localparam int VB    = VALUE_BITS;
  localparam int SWD   = VB + 2;
  localparam int PW    = GAIN_W + SWD;
  localparam int XW    = VB + FRAC_BITS;
  localparam int ACW   = ((XW > PW) ? XW : PW) + 1;
  localparam int CW    = SCALE_W;
  localparam int NC1   = (SWD + CW - 1) / CW;
  localparam int NC2   = (ACW + CW - 1) / CW;
  localparam int OPW   = NC2 * CW;
  localparam int MW    = OPW + GAIN_W + 1;
  localparam int CNTW  = $clog2(NC2 + 1);
  localparam int SH    = 2 * FRAC_BITS;
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDOUT = 13'b0000000000010,
    S_FET0  = 13'b0000000000100,
    S_FET1  = 13'b0000000001000,
    S_FET2  = 13'b0000000010000,
    S_PREP  = 13'b0000000100000,
    S_MUL1  = 13'b0000001000000,
    S_ACC   = 13'b0000010000000,
    S_MUL2  = 13'b0000100000000,
    S_RND   = 13'b0001000000000,
    S_FIN   = 13'b0010000000000,
    S_BND   = 13'b0100000000000,
    S_RESP  = 13'b1000000000000
  } state_t;

  state_t state;

  logic [SIZE_W-1:0]  active_size;
  logic [GAIN_W-1:0]  neighbor_gain;
  logic [SCALE_W-1:0] center_scale;

  logic signed [VB-1:0] field_mem [DEPTH];
  logic signed [VB-1:0] src_mem [DEPTH];
  logic signed [VB-1:0] fd0, fd1, sd;
  logic [AW-1:0] ra0, ra1, fwa;
  logic          fwe;
  logic signed [VB-1:0] fwd;

  logic [NW-1:0] n1, row, col, bi;
  logic [1:0]    bsub;
  logic [AW-1:0] rbase, bbase, nbase, caddr;
  logic [7:0]    sw_left;
  logic          sat_seen, rd_inside;

  logic signed [VB:0]    ud;
  logic signed [SWD-1:0] nsum;
  logic signed [VB-1:0]  x0;
  logic                  sneg, neg;
  logic [OPW-1:0]        opnd;
  logic [MW-1:0]         macc;
  logic [CNTW-1:0]       cnt;

  // Accept and address decode
  logic          accept, in_store, res_set;
  logic [AW-1:0] in_idx;
  logic signed [63:0] ld_src, ld_start;
  logic signed [VB-1:0] ld_src_c, ld_start_c;
  logic [NW-1:0] n_clamped;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_store = (int'(in_data.cell_row) < EDGE) && (int'(in_data.cell_col) < EDGE);
  assign in_idx = AW'(int'(in_data.cell_row) * EDGE + int'(in_data.cell_col));
  assign ld_src   = 64'(in_data.source_value);
  assign ld_start = 64'(in_data.start_value);
  assign ld_src_c = (ld_src > VMAX) ? VB'(VMAX) : (ld_src < VMIN) ? VB'(VMIN) : VB'(ld_src);
  assign ld_start_c = (ld_start > VMAX) ? VB'(VMAX) :
                      (ld_start < VMIN) ? VB'(VMIN) : VB'(ld_start);
  assign n_clamped = (active_size == '0) ? NW'(1) :
                     (int'(active_size) > GRID_MAX) ? NW'(GRID_MAX) : NW'(active_size);
  assign caddr = rbase + AW'(col);
  // A result is produced straight away for loads and unknown requests.
  assign res_set = (accept && !(in_data.req_type inside {REQ_RUN, REQ_READ})) ||
                   state == S_RDOUT || state == S_RESP;

  // Relaxation arithmetic around the shared multiplier
  logic [SWD-1:0]   sm;
  logic [VB-1:0]    xm;
  logic [ACW-1:0]   xw, pw, acc_v;
  logic             acc_neg;
  logic [GAIN_W-1:0] mul_a;
  logic [CW-1:0]    mul_b;
  logic [GAIN_W+CW-1:0] prod;
  logic [MW-1:0]    q;
  logic [MW-1:0]    lim;
  logic             sat_now;
  logic [VB-1:0]    res_mag;

  assign sm = nsum[SWD-1] ? SWD'(-nsum) : SWD'(nsum);
  assign xm = x0[VB-1] ? VB'(-x0) : VB'(x0);
  assign xw = ACW'(xm) << FRAC_BITS;
  assign pw = ACW'(macc[PW-1:0]);
  always_comb begin
    if (x0[VB-1] == sneg) begin
      acc_v   = xw + pw;
      acc_neg = sneg;
    end else if (xw < pw) begin
      acc_v   = pw - xw;
      acc_neg = sneg;
    end else begin
      acc_v   = xw - pw;
      acc_neg = x0[VB-1];
    end
  end
  assign mul_a = (state == S_MUL2) ? GAIN_W'(center_scale) : neighbor_gain;
  assign mul_b = opnd[OPW-1 -: CW];
  assign prod  = (GAIN_W+CW)'(mul_a) * (GAIN_W+CW)'(mul_b);
  assign q     = macc >> SH;
  assign lim   = neg ? (MW'(1) << (VB - 1)) : ((MW'(1) << (VB - 1)) - MW'(1));
  assign sat_now = q > lim;
  assign res_mag = sat_now ? VB'(lim) : VB'(q);

  // Memory ports
  always_comb begin
    ra0 = in_idx;
    ra1 = caddr + AW'(EDGE);
    if (state == S_FET0) begin
      ra0 = caddr - AW'(EDGE);
    end else if (state == S_FET1) begin
      ra0 = caddr - AW'(1);
      ra1 = caddr + AW'(1);
    end
    fwe = 1'b0;
    fwa = in_idx;
    fwd = ld_start_c;
    if (accept && in_data.req_type == REQ_LOAD && in_store) begin
      fwe = 1'b1;
    end else if (state == S_FIN) begin
      fwe = 1'b1;
      fwa = caddr;
      fwd = neg ? VB'(-res_mag) : res_mag;
    end else if (state == S_BND) begin
      fwe = 1'b1;
      fwd = '0;
      case (bsub)
        2'd0:    fwa = AW'(bi);
        2'd1:    fwa = nbase + AW'(bi);
        2'd2:    fwa = bbase;
        default: fwa = bbase + AW'(n1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fd0 <= field_mem[ra0];
    fd1 <= field_mem[ra1];
    if (fwe) begin
      field_mem[fwa] <= fwd;
    end
  end

  always_ff @(posedge clk) begin
    sd <= src_mem[caddr];
    if (accept && in_data.req_type == REQ_LOAD && in_store) begin
      src_mem[in_idx] <= ld_src_c;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_size   <= ACTIVE_SIZE_RST;
      neighbor_gain <= NEIGHBOR_GAIN_RST;
      center_scale  <= CENTER_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_SIZE:   active_size   <= cfg_data[SIZE_W-1:0];
        CFG_NEIGHBOR_GAIN: neighbor_gain <= cfg_data[GAIN_W-1:0];
        CFG_CENTER_SCALE:  center_scale  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_FET1: ud <= (VB+1)'(fd0) + (VB+1)'(fd1);
      S_FET2: begin
        nsum <= SWD'(ud) + SWD'(fd0) + SWD'(fd1);
        x0   <= sd;
      end
      S_PREP: begin
        sneg <= nsum[SWD-1];
        opnd <= OPW'(sm) << (OPW - NC1 * CW);
        macc <= '0;
      end
      S_MUL1, S_MUL2: begin
        macc <= (macc << CW) + MW'(prod);
        opnd <= opnd << CW;
      end
      S_ACC: begin
        neg  <= acc_neg;
        opnd <= OPW'(acc_v);
        macc <= '0;
      end
      S_RND: macc <= macc + (MW'(1) << (SH - 1));
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sat_seen  <= 1'b0;
      cnt       <= '0;
    end else begin
      out_valid <= res_set || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_inside <= in_store;
            case (in_data.req_type)
              REQ_LOAD: begin
                out_data.cell_value <= '0;
                out_data.done_res  <= 1'b1;
                out_data.saturated <= 1'b0;
              end
              REQ_RUN: begin
                sat_seen <= 1'b0;
                sw_left  <= in_data.sweep_count;
                n1       <= n_clamped + NW'(1);
                nbase    <= AW'((int'(n_clamped) + 1) * EDGE);
                row      <= NW'(1);
                col      <= NW'(1);
                rbase    <= AW'(EDGE);
                state    <= (in_data.sweep_count == '0) ? S_RESP : S_FET0;
              end
              REQ_READ: state <= S_RDOUT;
              default: begin
                out_data  <= '0;
              end
            endcase
          end
        end
        S_RDOUT: begin
          out_data.cell_value <= rd_inside ? 32'(64'(fd0)) : '0;
          out_data.done_res  <= 1'b0;
          out_data.saturated <= 1'b0;
          state <= S_IDLE;
        end
        S_FET0: state <= S_FET1;
        S_FET1: state <= S_FET2;
        S_FET2: state <= S_PREP;
        S_PREP: begin
          cnt   <= CNTW'(NC1);
          state <= S_MUL1;
        end
        S_MUL1: begin
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          cnt   <= CNTW'(NC2);
          state <= S_MUL2;
        end
        S_MUL2: begin
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= S_RND;
          end
        end
        S_RND: state <= S_FIN;
        S_FIN: begin
          if (sat_now) begin
            sat_seen <= 1'b1;
          end
          state <= S_FET0;
          if (col == n1 - NW'(1)) begin
            col <= NW'(1);
            if (row == n1 - NW'(1)) begin
              bi    <= '0;
              bsub  <= '0;
              bbase <= '0;
              state <= S_BND;
            end else begin
              row   <= row + NW'(1);
              rbase <= rbase + AW'(EDGE);
            end
          end else begin
            col <= col + NW'(1);
          end
        end
        S_BND: begin
          bsub <= bsub + 2'd1;
          if (bsub == 2'd3) begin
            if (bi == n1) begin
              sw_left <= sw_left - 8'd1;
              row     <= NW'(1);
              col     <= NW'(1);
              rbase   <= AW'(EDGE);
              state   <= (sw_left == 8'd1) ? S_RESP : S_FET0;
            end else begin
              bi    <= bi + NW'(1);
              bbase <= bbase + AW'(EDGE);
            end
          end
        end
        S_RESP: begin
          out_data.cell_value <= '0;
          out_data.done_res  <= 1'b1;
          out_data.saturated <= sat_seen;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall)
    else $error("input taken while a request is in progress");

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.req_type == REQ_RUN && in_data.sweep_count != 8'd0
    |=> state == S_FET0)
    else $error("run request did not start a sweep");

  a_resp_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP || state == S_RDOUT) |-> !out_valid)
    else $error("result register overwritten before its transfer");
`endif

endmodule

>>> tb/tb_gauss_seidel_diffusion_solver_unit.sv
// ----------------------------------------------------------------------------
// tb_gauss_seidel_diffusion_solver_unit
// Self-checking bench for the diffusion solver. A short table of directed
// items is followed by random phases under several register settings and
// idling patterns. Results are checked by a predictor or the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gauss_seidel_diffusion_solver_unit;
  import gsds_pkg::*;

  localparam int EDGE      = GRID_MAX_DEF + 2;
  localparam int CELLS     = EDGE * EDGE;
  localparam int STALL_MAX = 200000;
  localparam logic [1:0] REQ_BAD = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } table_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_ACTIVE_SIZE;
  logic [CFG_W-1:0] cfg_data = '0;

  // Predictor state.
  logic signed [31:0] field_mem [CELLS];
  logic signed [31:0] source_mem [CELLS];
  bit                 loaded [CELLS];
  logic [SIZE_W-1:0]  size_reg;
  logic [GAIN_W-1:0]  gain_reg;
  logic [SCALE_W-1:0] scale_reg;
  bit                 sat_flag;

  out_item_t pending_results[$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off = 0;

  gauss_seidel_diffusion_solver_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [31:0] relax_cell(logic signed [31:0] x0,
                                                    logic signed [34:0] nsum);
    logic signed [127:0] xs, ns, gs, cs, acc, mag, t, lim;
    bit neg;
    xs = x0;
    ns = nsum;
    gs = $signed({1'b0, gain_reg});
    cs = $signed({1'b0, scale_reg});
    acc = (xs <<< FRAC_BITS_DEF) + gs * ns;
    neg = acc < 0;
    mag = neg ? -acc : acc;
    t = (mag * cs + (128'sd1 <<< (2 * FRAC_BITS_DEF - 1))) >>> (2 * FRAC_BITS_DEF);
    lim = neg ? 128'sd2147483648 : 128'sd2147483647;
    if (t > lim) begin
      sat_flag = 1'b1;
      t = lim;
    end
    return neg ? 32'(-t) : 32'(t);
  endfunction

  function automatic int clamped_size();
    if (size_reg < 1) return 1;
    if (size_reg > GRID_MAX_DEF) return GRID_MAX_DEF;
    return int'(size_reg);
  endfunction

  function automatic out_item_t solve_item(in_item_t it);
    out_item_t r;
    bit in_grid;
    int idx, n, c;
    logic signed [34:0] s;
    r = '0;
    in_grid = it.cell_row < EDGE && it.cell_col < EDGE;
    idx = int'(it.cell_row) * EDGE + int'(it.cell_col);
    case (it.req_type)
      REQ_LOAD: begin
        if (in_grid) begin
          source_mem[idx] = it.source_value;
          field_mem[idx] = it.start_value;
          loaded[idx] = 1'b1;
        end
        r.done_res = 1'b1;
      end
      REQ_RUN: begin
        sat_flag = 1'b0;
        n = clamped_size();
        for (int k = 0; k < it.sweep_count; k++) begin
          for (int i = 1; i <= n; i++)
            for (int j = 1; j <= n; j++) begin
              c = i * EDGE + j;
              s = 35'(field_mem[c - EDGE]) + 35'(field_mem[c + EDGE]) +
                  35'(field_mem[c - 1]) + 35'(field_mem[c + 1]);
              field_mem[c] = relax_cell(source_mem[c], s);
            end
          for (int i = 0; i <= n + 1; i++) begin
            field_mem[i] = '0;
            field_mem[(n + 1) * EDGE + i] = '0;
            field_mem[i * EDGE] = '0;
            field_mem[i * EDGE + n + 1] = '0;
          end
        end
        r.done_res = 1'b1;
        r.saturated = sat_flag;
      end
      REQ_READ: if (in_grid) r.cell_value = field_mem[idx];
      default: ;
    endcase
    return r;
  endfunction

  // Offers one item and waits for its transfer; valid stays high into the
  // next item unless that item begins with an idle gap.
  task automatic offer_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    r = solve_item(it);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_registers(int unsigned sz, int unsigned gain, int unsigned scale);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_ACTIVE_SIZE;
    cfg_data <= CFG_W'(sz);
    @(posedge clk);
    cfg_index <= CFG_NEIGHBOR_GAIN;
    cfg_data <= CFG_W'(gain);
    @(posedge clk);
    cfg_index <= CFG_CENTER_SCALE;
    cfg_data <= CFG_W'(scale);
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = SIZE_W'(sz);
    gain_reg = GAIN_W'(gain);
    scale_reg = SCALE_W'(scale);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed(32'($urandom_range(65536 * 8))) - 32'sd262144;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_load(int r, int c);
    in_item_t it;
    it = '0;
    it.req_type = REQ_LOAD;
    it.cell_row = 7'(r);
    it.cell_col = 7'(c);
    it.source_value = pick_value();
    it.start_value = pick_value();
    it.sweep_count = 8'($urandom);
    return it;
  endfunction

  // Every cell a run touches must have been loaded first.
  task automatic fill_region();
    int n;
    n = clamped_size();
    for (int r = 0; r <= n + 1; r++)
      for (int c = 0; c <= n + 1; c++)
        if (!loaded[r * EDGE + c]) offer_item(make_load(r, c));
  endtask

  task automatic random_phase(int count, bit deep_runs);
    in_item_t it;
    int n, sel;
    n = clamped_size();
    fill_region();
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      it = make_load($urandom_range(n + 1), $urandom_range(n + 1));
      if (sel >= 55 && sel < 82) begin
        it.req_type = REQ_READ;
        if ($urandom_range(9) == 0) begin
          it.cell_row = 7'($urandom_range(127, EDGE));
          it.cell_col = 7'($urandom);
        end
      end else if (sel >= 82 && sel < 94) begin
        it.req_type = REQ_RUN;
        it.sweep_count = deep_runs ? 8'($urandom) : 8'($urandom_range(3));
      end else if (sel >= 94) begin
        it.cell_row = 7'($urandom);
        it.cell_col = 7'($urandom);
        if (it.cell_row < EDGE && it.cell_col < EDGE) it.req_type = REQ_BAD;
      end
      offer_item(it);
    end
  endtask

  task automatic directed_part();
    table_row_t rows[$];
    table_row_t tr;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        tr.item = make_load(r, c);
        if (r == 1 && c == 1) begin
          tr.item.source_value = 32'sh7fffffff;
          tr.item.start_value = 32'sh80000000;
        end
        if (r == 0 && c == 2) tr.item.start_value = 32'sh7fffffff;
        tr.typed = 1'b1;
        tr.want = '{cell_value: 32'sd0, done_res: 1'b1, saturated: 1'b0};
        rows.push_back(tr);
      end
    tr.item = '0;
    tr.item.req_type = REQ_READ;
    tr.item.cell_row = 7'd1;
    tr.item.cell_col = 7'd1;
    tr.want = '{cell_value: 32'sh80000000, done_res: 1'b0, saturated: 1'b0};
    rows.push_back(tr);
    tr.item.cell_row = 7'd0;
    tr.item.cell_col = 7'd2;
    tr.want.cell_value = 32'sh7fffffff;
    rows.push_back(tr);
    // Coordinates beyond the store read as zero and loads there do nothing.
    tr.item.cell_row = 7'd127;
    tr.item.cell_col = 7'd1;
    tr.want.cell_value = '0;
    rows.push_back(tr);
    tr.item.cell_row = 7'd1;
    tr.item.cell_col = 7'd66;
    rows.push_back(tr);
    tr.item = '1;
    tr.item.req_type = REQ_BAD;
    tr.item.cell_row = 7'd1;
    tr.item.cell_col = 7'd1;
    rows.push_back(tr);
    tr.item.req_type = REQ_LOAD;
    tr.item.cell_row = 7'd66;
    tr.item.cell_col = 7'd0;
    tr.want = '{cell_value: 32'sd0, done_res: 1'b1, saturated: 1'b0};
    rows.push_back(tr);
    // A run of zero sweeps leaves even the boundary ring untouched.
    tr.item = '0;
    tr.item.req_type = REQ_RUN;
    rows.push_back(tr);
    tr.item.req_type = REQ_READ;
    tr.item.cell_col = 7'd2;
    tr.want = '{cell_value: 32'sh7fffffff, done_res: 1'b0, saturated: 1'b0};
    rows.push_back(tr);
    tr.typed = 1'b0;
    tr.item = '0;
    tr.item.req_type = REQ_RUN;
    tr.item.sweep_count = 8'd1;
    rows.push_back(tr);
    tr.item.req_type = REQ_READ;
    tr.item.cell_row = 7'd1;
    tr.item.cell_col = 7'd1;
    rows.push_back(tr);
    tr.item.cell_row = 7'd0;
    tr.item.cell_col = 7'd1;
    tr.typed = 1'b1;
    tr.want = '0;
    rows.push_back(tr);
    foreach (rows[i]) offer_item(rows[i].item, rows[i].typed, rows[i].want);
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.cell_value !== want.cell_value || out_data.done_res !== want.done_res ||
            out_data.saturated !== want.saturated) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("tb_gauss_seidel_diffusion_solver_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      field_mem[i] = '0;
      source_mem[i] = '0;
      loaded[i] = 1'b0;
    end
    size_reg = ACTIVE_SIZE_RST;
    gain_reg = NEIGHBOR_GAIN_RST;
    scale_reg = CENTER_SCALE_RST;
    sat_flag = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_registers(1, 0, 65536);
    directed_part();

    // Random phases cycle through the idling patterns and register settings.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 75; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 75; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      case (p)
        0: set_registers(0, 16384, 32768);
        1: set_registers(3, 32'h7fffffff, 131071);
        2: set_registers(4, $urandom, $urandom_range(131071));
        3: set_registers(2, 65536, 13107);
        4: set_registers(5, $urandom_range(65536), 0);
        5: set_registers(1, $urandom, $urandom);
        6: set_registers(3, 8192, 43690);
        default: set_registers(4, $urandom, 65536);
      endcase
      random_phase(60, p == 0 || p == 5);
    end

    // The receiver holds off for a long stretch while items keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_registers(2, 4096, 52429);
    fill_region();
    hold_off <= 300;
    random_phase(40, 1'b0);

    drain();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb_gauss_seidel_diffusion_solver_unit: done, clean");
    end else begin
      $display("tb_gauss_seidel_diffusion_solver_unit: done, errors");
    end
    $finish;
  end

endmodule

>>> gauss_seidel_diffusion_solver_unit.f
src/gsds_pkg.sv
src/gauss_seidel_diffusion_solver_unit.sv
tb/tb_gauss_seidel_diffusion_solver_unit.sv
